// File: rtl/assert_macros.svh
// Assertion macros shared by the padded box and ray slab test RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every rising clock edge outside reset.
`define PBG_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Implication checked on every rising clock edge outside reset.
`define PBG_ASSERT_IMP(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) else $error(msg);

`endif

// File: rtl/pbg_pkg.sv
// Shared types and constants for the padded box grow and ray slab test.
package pbg_pkg;

  localparam int COORD_W = 32;
  localparam int FRAC_W  = 16;
  localparam int PAD_W   = 21;
  localparam int DVD_W   = COORD_W + FRAC_W;
  localparam int CNT_W   = $clog2(DVD_W);
  localparam int AXES    = 3;

  localparam logic [PAD_W-1:0] PAD_RESET = PAD_W'(3277);

  localparam logic signed [COORD_W-1:0] CMAX = {1'b0, {(COORD_W-1){1'b1}}};
  localparam logic signed [COORD_W-1:0] CMIN = {1'b1, {(COORD_W-1){1'b0}}};
  localparam logic signed [COORD_W-1:0] EPS_RAW = COORD_W'((64'd1 << FRAC_W) / 64'd1000000);
  localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(DVD_W - 1);

  localparam logic ACT_GROW = 1'b0;
  localparam logic ACT_RAY  = 1'b1;

  typedef logic signed [COORD_W-1:0] coord_t;

  typedef struct packed {
    logic acc_grow;
    logic acc_ray;
    logic div_step;
    logic sat_load;
    logic res_load;
  } cmd_t;

  typedef struct packed {
    logic out_full;
  } sts_t;

endpackage

// File: rtl/pbg_div.sv
// Radix-2 restoring divider, one quotient bit per step.
module pbg_div (
  input  logic                      clk_i,
  input  logic                      load_i,
  input  logic                      step_i,
  input  logic [pbg_pkg::DVD_W-1:0] dvd_i,
  input  logic [pbg_pkg::COORD_W-1:0] dsr_i,
  output logic [pbg_pkg::DVD_W-1:0] quo_o
);
  import pbg_pkg::*;

  logic [DVD_W-1:0]   dvd_q, dvd_d, quo_q, quo_d;
  logic [COORD_W-1:0] dsr_q, rem_q, rem_d;
  logic [COORD_W:0]   rem_s;
  logic               ge;

  always_comb begin
    rem_s = {rem_q, dvd_q[DVD_W-1]};
    ge    = rem_s >= {1'b0, dsr_q};
    rem_d = ge ? COORD_W'(rem_s - {1'b0, dsr_q}) : rem_s[COORD_W-1:0];
    dvd_d = {dvd_q[DVD_W-2:0], 1'b0};
    quo_d = {quo_q[DVD_W-2:0], ge};
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      dvd_q <= dvd_i;
      dsr_q <= dsr_i;
      rem_q <= '0;
      quo_q <= '0;
    end else if (step_i) begin
      dvd_q <= dvd_d;
      rem_q <= rem_d;
      quo_q <= quo_d;
    end
  end

  assign quo_o = quo_q;

endmodule

// File: rtl/pbg_dp.sv
// Datapath: box corners, slab dividers, t reduction and result register.
`include "assert_macros.svh"
module pbg_dp (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  pbg_pkg::cmd_t               cmd_i,
  output pbg_pkg::sts_t               sts_o,
  input  logic                        cfg_we_i,
  input  logic [pbg_pkg::PAD_W-1:0]   cfg_wdata_i,
  input  pbg_pkg::coord_t             pos_i [pbg_pkg::AXES],
  input  pbg_pkg::coord_t             dir_i [pbg_pkg::AXES],
  input  logic                        m_ready_i,
  output logic                        m_valid_o,
  output logic                        hit_o
);
  import pbg_pkg::*;

  logic [PAD_W-1:0] pad_q;
  coord_t lo_q [AXES];
  coord_t hi_q [AXES];
  logic   empty_q;

  logic [AXES-1:0] sneg_n_q, sneg_f_q, zero_q, inside_q;
  coord_t tmin_q [AXES];
  coord_t tmax_q [AXES];
  logic   m_valid_q, hit_q, hit_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pad_q <= PAD_RESET;
    end else if (cfg_we_i) begin
      pad_q <= cfg_wdata_i;
    end
  end

  for (genvar k = 0; k < AXES; k++) begin : g_axis
    logic signed [COORD_W:0] sub, add, dn, df, pos_e;
    coord_t lo_new, hi_new, near, far;
    logic   dneg;
    logic [COORD_W-1:0] dmag, mag_n, mag_f;
    logic [DVD_W-1:0]   quo_n, quo_f;
    coord_t tn, tf;

    always_comb begin
      pos_e  = {pos_i[k][COORD_W-1], pos_i[k]};
      sub    = pos_e - {{(COORD_W+1-PAD_W){1'b0}}, pad_q};
      add    = pos_e + {{(COORD_W+1-PAD_W){1'b0}}, pad_q};
      lo_new = (sub[COORD_W] != sub[COORD_W-1]) ? CMIN : sub[COORD_W-1:0];
      hi_new = (add[COORD_W] != add[COORD_W-1]) ? CMAX : add[COORD_W-1:0];
      dneg   = dir_i[k][COORD_W-1];
      dmag   = dneg ? COORD_W'(-dir_i[k]) : dir_i[k];
      near   = dneg ? hi_q[k] : lo_q[k];
      far    = dneg ? lo_q[k] : hi_q[k];
      dn     = {near[COORD_W-1], near} - pos_e;
      df     = {far[COORD_W-1], far} - pos_e;
      mag_n  = dn[COORD_W] ? COORD_W'(-dn) : dn[COORD_W-1:0];
      mag_f  = df[COORD_W] ? COORD_W'(-df) : df[COORD_W-1:0];
      // Quotient magnitude clamped to the largest coordinate, then signed.
      tn = (quo_n > DVD_W'(CMAX)) ? CMAX : quo_n[COORD_W-1:0];
      tf = (quo_f > DVD_W'(CMAX)) ? CMAX : quo_f[COORD_W-1:0];
      if (sneg_n_q[k]) tn = -tn;
      if (sneg_f_q[k]) tf = -tf;
    end

    pbg_div u_div_n (
      .clk_i  (clk_i),
      .load_i (cmd_i.acc_ray),
      .step_i (cmd_i.div_step),
      .dvd_i  ({mag_n, {FRAC_W{1'b0}}}),
      .dsr_i  (dmag),
      .quo_o  (quo_n)
    );

    pbg_div u_div_f (
      .clk_i  (clk_i),
      .load_i (cmd_i.acc_ray),
      .step_i (cmd_i.div_step),
      .dvd_i  ({mag_f, {FRAC_W{1'b0}}}),
      .dsr_i  (dmag),
      .quo_o  (quo_f)
    );

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        lo_q[k] <= '0;
        hi_q[k] <= '0;
      end else if (cmd_i.acc_grow) begin
        if (empty_q) begin
          lo_q[k] <= lo_new;
          hi_q[k] <= hi_new;
        end else if (pos_i[k] < lo_q[k]) begin
          lo_q[k] <= lo_new;
        end else if (pos_i[k] > hi_q[k]) begin
          hi_q[k] <= hi_new;
        end
      end
    end

    always_ff @(posedge clk_i) begin
      if (cmd_i.acc_ray) begin
        sneg_n_q[k] <= dn[COORD_W] ^ dneg;
        sneg_f_q[k] <= df[COORD_W] ^ dneg;
        zero_q[k]   <= (dir_i[k] == '0);
        inside_q[k] <= (pos_i[k] >= lo_q[k]) && (pos_i[k] <= hi_q[k]);
      end
      if (cmd_i.sat_load) begin
        tmin_q[k] <= tn;
        tmax_q[k] <= tf;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      empty_q <= 1'b1;
    end else if (cmd_i.acc_grow) begin
      empty_q <= 1'b0;
    end
  end

  // Entry t is the largest near-plane t, exit t the smallest far-plane t,
  // over the axes whose direction is non-zero.
  always_comb begin
    coord_t t0, t1;
    logic   bnd, ok;
    t0  = '0;
    t1  = '0;
    bnd = 1'b0;
    ok  = !empty_q;
    for (int k = 0; k < AXES; k++) begin
      if (zero_q[k]) begin
        if (!inside_q[k]) ok = 1'b0;
      end else if (!bnd) begin
        t0  = tmin_q[k];
        t1  = tmax_q[k];
        bnd = 1'b1;
      end else begin
        if (tmin_q[k] > t0) t0 = tmin_q[k];
        if (tmax_q[k] < t1) t1 = tmax_q[k];
      end
    end
    hit_d = ok && (!bnd || ((t0 < t1) && (t1 > EPS_RAW)));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (cmd_i.res_load) begin
      m_valid_q <= 1'b1;
    end else if (m_ready_i) begin
      m_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.res_load) hit_q <= hit_d;
  end

  assign sts_o.out_full = m_valid_q;
  assign m_valid_o      = m_valid_q;
  assign hit_o          = hit_q;

  `PBG_ASSERT(a_box_order, empty_q || ((lo_q[0] <= hi_q[0]) && (lo_q[1] <= hi_q[1]) && (lo_q[2] <= hi_q[2])), "box corners out of order")
  `PBG_ASSERT_IMP(a_res_shown, cmd_i.res_load, m_valid_q, "result not presented after load")
  `PBG_ASSERT_IMP(a_grow_fills, cmd_i.acc_grow, !empty_q, "box still empty after a grow")

endmodule

// File: rtl/pbg_ctrl.sv
// Controller state machine: accept, divide, saturate, deliver.
`include "assert_macros.svh"
module pbg_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          s_valid_i,
  input  logic          s_action_i,
  input  logic          m_ready_i,
  input  pbg_pkg::sts_t sts_i,
  output logic          s_ready_o,
  output pbg_pkg::cmd_t cmd_o
);
  import pbg_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_DIV  = 2'd1;
  localparam logic [1:0] ST_SAT  = 2'd2;
  localparam logic [1:0] ST_RES  = 2'd3;

  logic [1:0]       state_q, state_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             acc, res_go;

  always_comb begin
    acc     = s_valid_i && (state_q == ST_IDLE);
    res_go  = (state_q == ST_RES) && (!sts_i.out_full || m_ready_i);
    state_d = state_q;
    cnt_d   = cnt_q;
    cmd_o   = '0;
    cmd_o.acc_grow = acc && (s_action_i == ACT_GROW);
    cmd_o.acc_ray  = acc && (s_action_i == ACT_RAY);
    case (state_q)
      ST_IDLE: begin
        cnt_d = '0;
        if (cmd_o.acc_ray) state_d = ST_DIV;
      end
      ST_DIV: begin
        cmd_o.div_step = 1'b1;
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == LAST_STEP) state_d = ST_SAT;
      end
      ST_SAT: begin
        cmd_o.sat_load = 1'b1;
        state_d = ST_RES;
      end
      ST_RES: begin
        cmd_o.res_load = res_go;
        if (res_go) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  assign s_ready_o = (state_q == ST_IDLE);

  `PBG_ASSERT_IMP(a_ray_divides, cmd_o.acc_ray, state_q == ST_DIV, "ray accepted without divide")
  `PBG_ASSERT_IMP(a_div_ends, (state_q == ST_DIV) && (cnt_q == LAST_STEP), state_q == ST_SAT, "divide did not end")
  `PBG_ASSERT_IMP(a_res_waits, (state_q == ST_RES) && sts_i.out_full && !m_ready_i, state_q == ST_RES, "result overwrote waiting word")

endmodule

// File: rtl/padded_box_grow_and_ray_slab_test.sv
// Top level of the padded box grow and ray slab test.
// The block keeps an axis-aligned box in signed Q16.16 and takes one word at a
// time on the slave stream. A grow word (tuser 0) widens the box by the point
// plus or minus pad_offset. It is finished in the cycle it is accepted, with no
// output word, and the next word can be accepted in the following cycle. A ray
// word (tuser 1) is tested against the box with the slab method and yields one
// output word carrying the hit flag. The accepting edge loads the six radix-2
// dividers (near and far plane for each axis, working side by side). In the
// divide state each edge produces one quotient bit of the 48-bit scaled
// difference. The saturate state then saturates and signs the slab t values,
// and the result state reduces them and registers the flag. No new word is
// accepted while a ray is in progress; the next word can be accepted in the
// cycle the result word becomes valid. The output register lets the next word
// be accepted while a result still waits to be taken. A ray that finishes
// while the previous result is still waiting holds in its final step until that
// word is taken. pad_offset is written through cfg_we_i and cfg_wdata_i; the
// user must write it only while the block is idle, the block does not enforce it.
module padded_box_grow_and_ray_slab_test (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [pbg_pkg::PAD_W-1:0] cfg_wdata_i,
  input  logic                      s_axis_tvalid,
  output logic                      s_axis_tready,
  // pos_x, pos_y, pos_z, dir_x, dir_y, dir_z from the lowest bit up
  input  logic [6*pbg_pkg::COORD_W-1:0] s_axis_tdata,
  // action
  input  logic                      s_axis_tuser,
  output logic                      m_axis_tvalid,
  input  logic                      m_axis_tready,
  // ray_hits, then seven zero bits
  output logic [7:0]                m_axis_tdata
);
  import pbg_pkg::*;

  cmd_t   cmd;
  sts_t   sts;
  coord_t pos [AXES];
  coord_t dir [AXES];
  logic   hit;

  // The first three coordinates of the word are the position, the last three
  // the direction.
  for (genvar k = 0; k < AXES; k++) begin : g_unpack
    assign pos[k] = s_axis_tdata[k*COORD_W +: COORD_W];
    assign dir[k] = s_axis_tdata[(k+AXES)*COORD_W +: COORD_W];
  end

  pbg_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_valid_i  (s_axis_tvalid),
    .s_action_i (s_axis_tuser),
    .m_ready_i  (m_axis_tready),
    .sts_i      (sts),
    .s_ready_o  (s_axis_tready),
    .cmd_o      (cmd)
  );

  pbg_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .pos_i       (pos),
    .dir_i       (dir),
    .m_ready_i   (m_axis_tready),
    .m_valid_o   (m_axis_tvalid),
    .hit_o       (hit)
  );

  assign m_axis_tdata = {7'b0, hit};

endmodule
